// ===== hdl/tsga_pkg.sv =====
// shared constants, types and the cell update rule for the grid automaton step
package tsga_pkg;

  localparam int DEF_MAX_WIDTH  = 32;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam int STATE_W       = 2;
  localparam int ROW_INDEX_W   = 10;
  localparam int COL_INDEX_W   = 5;
  localparam int GRID_WIDTH_W  = 6;
  localparam int GRID_HEIGHT_W = 11;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 11;
  localparam int QUEUE_DEPTH   = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT = 2'd1;

  localparam logic [GRID_WIDTH_W-1:0]  GRID_WIDTH_RESET  = 6'd32;
  localparam logic [GRID_HEIGHT_W-1:0] GRID_HEIGHT_RESET = 11'd1024;

  localparam logic [STATE_W-1:0] CELL_OFF  = 2'd0;
  localparam logic [STATE_W-1:0] CELL_ON   = 2'd1;
  localparam logic [STATE_W-1:0] CELL_DEAD = 2'd2;
  localparam logic [STATE_W-1:0] CELL_ALT  = 2'd3;

  // classification of one accepted cell
  typedef struct packed {
    logic emit;    // a result for the row above is due
    logic up_ok;   // the row two above exists
    logic last;    // final cell of the frame, flush follows
  } item_flags_t;

  function automatic logic [STATE_W-1:0] next_cell(input logic [STATE_W-1:0] centre,
                                                   input logic any_on);
    logic [STATE_W-1:0] res;
    case (centre)
      CELL_ON:   res = CELL_DEAD;
      CELL_DEAD: res = CELL_OFF;
      default:   res = any_on ? CELL_ON : CELL_OFF;
    endcase
    return res;
  endfunction

endpackage

// ===== hdl/three_state_grid_automaton_step.sv =====
// top level of the streaming next-generation unit for the three-state grid automaton
// cells of one generation arrive in raster order, one per input beat, and the block
// returns the next generation of cell (r,c) once cell (r+1,c) has arrived; the last
// cell of a frame flushes the whole final row, the final result beat carrying
// frame_end. a front end keeps the raster position and classifies each cell, a
// four-entry queue decouples it from the back end, and the back end runs a
// two-row line store with one write and two read ports, one cell at a time: RD1
// and RD2 read the centre and three neighbours from the store (the fourth is the
// incoming cell), CALC updates and writes back once any due result can enter
// the output register; the frame's last cell adds a flush. the input side keeps
// accepting up to four beats ahead of the back end, and a finished result waits
// in the output register without blocking the next cell's fetch. configuration
// writes (index 0 grid_width, index 1 grid_height) restart the frame at row 0,
// column 0 and are only to be issued while the block is idle
module three_state_grid_automaton_step #(
  parameter int MAX_WIDTH  = tsga_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = tsga_pkg::DEF_MAX_HEIGHT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [tsga_pkg::STATE_W-1:0]     in_cell_state,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [tsga_pkg::STATE_W-1:0]     out_next_state,
  output logic [tsga_pkg::ROW_INDEX_W-1:0] out_row_index,
  output logic [tsga_pkg::COL_INDEX_W-1:0] out_column_index,
  output logic                             out_frame_end,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tsga_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tsga_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int FW = $bits(tsga_pkg::item_flags_t);
  localparam int DW = tsga_pkg::STATE_W + CW + RW + FW;

  // front to queue
  logic                         push;
  logic [tsga_pkg::STATE_W-1:0] push_cell;
  logic [CW-1:0]                push_col;
  logic [RW-1:0]                push_row;
  tsga_pkg::item_flags_t        push_flags;
  logic [CW-1:0]                w_last;

  // queue to back
  logic                         q_full, q_valid, pop;
  logic [DW-1:0]                head_data;
  logic [tsga_pkg::STATE_W-1:0] head_cell;
  logic [CW-1:0]                head_col;
  logic [RW-1:0]                head_row;
  tsga_pkg::item_flags_t        head_flags;

  tsga_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cell_state (in_cell_state),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .q_full        (q_full),
    .push          (push),
    .push_cell     (push_cell),
    .push_col      (push_col),
    .push_row      (push_row),
    .push_flags    (push_flags),
    .w_last        (w_last)
  );

  // one queue entry per accepted cell beat
  tsga_queue #(
    .DATA_W (DW),
    .DEPTH  (tsga_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_cell, push_col, push_row, push_flags}),
    .pop       (pop),
    .head_data (head_data),
    .full      (q_full),
    .not_empty (q_valid)
  );

  assign {head_cell, head_col, head_row, head_flags} = head_data;

  // w_last is straight from config; only the user keeps it stable while work is queued
  tsga_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .pop              (pop),
    .head_cell        (head_cell),
    .head_col         (head_col),
    .head_row         (head_row),
    .head_flags       (head_flags),
    .w_last           (w_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_next_state   (out_next_state),
    .out_row_index    (out_row_index),
    .out_column_index (out_column_index),
    .out_frame_end    (out_frame_end)
  );

endmodule

// ===== hdl/tsga_front.sv =====
// front end: configuration registers, raster position and classification of each cell
module tsga_front #(
  parameter int MAX_WIDTH  = tsga_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = tsga_pkg::DEF_MAX_HEIGHT,
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [tsga_pkg::STATE_W-1:0]        in_cell_state,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tsga_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [tsga_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                q_full,
  output logic                                push,
  output logic [tsga_pkg::STATE_W-1:0]        push_cell,
  output logic [CW-1:0]                       push_col,
  output logic [RW-1:0]                       push_row,
  output tsga_pkg::item_flags_t               push_flags,
  output logic [CW-1:0]                       w_last
);

  logic [tsga_pkg::GRID_WIDTH_W-1:0]  grid_width_r;
  logic [tsga_pkg::GRID_HEIGHT_W-1:0] grid_height_r;
  logic [CW-1:0]                      col_r, col_nxt;
  logic [RW-1:0]                      row_r, row_nxt;
  logic [RW-1:0]                      h_last;
  logic                               cfg_hit;

  // clamp the sizes in use to 1..max
  always_comb begin
    int unsigned wv;
    int unsigned hv;
    wv = 32'(grid_width_r);
    hv = 32'(grid_height_r);
    if (wv < 1) wv = 1;
    if (wv > MAX_WIDTH) wv = MAX_WIDTH;
    if (hv < 1) hv = 1;
    if (hv > MAX_HEIGHT) hv = MAX_HEIGHT;
    w_last = CW'(wv - 1);
    h_last = RW'(hv - 1);
  end

  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && (cfg_index inside {tsga_pkg::REG_GRID_WIDTH,
                                                     tsga_pkg::REG_GRID_HEIGHT});

  assign in_stall  = q_full;
  assign push      = in_valid && !q_full;
  assign push_cell = (in_cell_state == tsga_pkg::CELL_ALT) ? tsga_pkg::CELL_OFF : in_cell_state;
  assign push_col  = col_r;
  assign push_row  = row_r;

  always_comb begin
    push_flags.emit  = (row_r != '0);
    push_flags.up_ok = (row_r > RW'(1));
    push_flags.last  = (row_r == h_last) && (col_r == w_last);
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_hit) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (push) begin
      if (push_flags.last) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (col_r == w_last) begin
        col_nxt = '0;
        row_nxt = row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= tsga_pkg::GRID_WIDTH_RESET;
      grid_height_r <= tsga_pkg::GRID_HEIGHT_RESET;
      col_r         <= '0;
      row_r         <= '0;
    end else begin
      if (cfg_valid && cfg_index == tsga_pkg::REG_GRID_WIDTH) begin
        grid_width_r <= cfg_data[tsga_pkg::GRID_WIDTH_W-1:0];
      end
      if (cfg_valid && cfg_index == tsga_pkg::REG_GRID_HEIGHT) begin
        grid_height_r <= cfg_data;
      end
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

// ===== hdl/tsga_queue.sv =====
// small register fifo between the front and back ends
module tsga_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = tsga_pkg::QUEUE_DEPTH,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int NW = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic [DATA_W-1:0] head_data,
  output logic              full,
  output logic              not_empty
);

  logic [DATA_W-1:0] slot_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [NW-1:0]     count_r;

  assign full      = (count_r == NW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + NW'(1);
        2'b01:   count_r <= count_r - NW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== hdl/tsga_back.sv =====
// back end: two-row line store, neighbourhood fetch, rule and end-of-frame flush
module tsga_back #(
  parameter int MAX_WIDTH  = tsga_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = tsga_pkg::DEF_MAX_HEIGHT,
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
  localparam int AW = $clog2(2 * MAX_WIDTH)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_valid,
  output logic                                pop,
  input  logic [tsga_pkg::STATE_W-1:0]        head_cell,
  input  logic [CW-1:0]                       head_col,
  input  logic [RW-1:0]                       head_row,
  input  tsga_pkg::item_flags_t               head_flags,
  input  logic [CW-1:0]                       w_last,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [tsga_pkg::STATE_W-1:0]        out_next_state,
  output logic [tsga_pkg::ROW_INDEX_W-1:0]    out_row_index,
  output logic [tsga_pkg::COL_INDEX_W-1:0]    out_column_index,
  output logic                                out_frame_end
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD1,
    ST_RD2,
    ST_CALC
  } bstate_t;

  localparam logic [AW-1:0] ROW1_BASE = AW'(MAX_WIDTH);

  logic [tsga_pkg::STATE_W-1:0] store [2 * MAX_WIDTH];

  bstate_t                      state_r, state_nxt;
  logic [tsga_pkg::STATE_W-1:0] cell_r;
  logic [RW-1:0]                row_r;
  tsga_pkg::item_flags_t        flags_r;
  logic                         flush_r, flush_nxt;
  logic [CW-1:0]                k_r, k_nxt;
  logic [tsga_pkg::STATE_W-1:0] rd0_r, rd1_r, left_r, centre_r;

  logic                         out_valid_r;
  logic [tsga_pkg::STATE_W-1:0] out_state_r;
  logic [tsga_pkg::ROW_INDEX_W-1:0] out_row_r;
  logic [tsga_pkg::COL_INDEX_W-1:0] out_col_r;
  logic                         out_end_r;

  logic          centre_slot, up_slot;
  logic [CW-1:0] k_left, k_right;
  logic [AW-1:0] raddr0, raddr1, waddr;
  logic          any_on, need_out, out_free, fire, done, load;
  logic [tsga_pkg::STATE_W-1:0] res;

  function automatic logic [AW-1:0] addr_of(input logic slot, input logic [CW-1:0] col);
    return slot ? ROW1_BASE + AW'(col) : AW'(col);
  endfunction

  // normal item: centre row is the one above; flush: centre is the last row itself
  assign centre_slot = flush_r ? row_r[0] : ~row_r[0];
  assign up_slot     = ~centre_slot;
  assign k_left      = (k_r == '0) ? k_r : k_r - CW'(1);
  assign k_right     = (k_r == w_last) ? k_r : k_r + CW'(1);

  assign raddr0 = (state_r == ST_RD1) ? addr_of(centre_slot, k_left)
                                      : addr_of(centre_slot, k_right);
  assign raddr1 = (state_r == ST_RD1) ? addr_of(centre_slot, k_r)
                                      : addr_of(up_slot, k_r);
  assign waddr  = addr_of(row_r[0], k_r);

  always_comb begin
    logic up_ok;
    up_ok  = flush_r ? flags_r.emit : flags_r.up_ok;
    any_on = ((k_r != '0) && left_r == tsga_pkg::CELL_ON) ||
             ((k_r != w_last) && rd0_r == tsga_pkg::CELL_ON) ||
             (up_ok && rd1_r == tsga_pkg::CELL_ON) ||
             (!flush_r && cell_r == tsga_pkg::CELL_ON);
  end

  assign res      = tsga_pkg::next_cell(centre_r, any_on);
  assign need_out = flush_r || flags_r.emit;
  assign out_free = !out_valid_r || !out_stall;
  assign fire     = (state_r == ST_CALC) && (!need_out || out_free);
  assign done     = flush_r ? (k_r == w_last) : !flags_r.last;
  assign load     = q_valid && ((state_r == ST_IDLE) || (fire && done));
  assign pop      = load;

  always_comb begin
    state_nxt = state_r;
    flush_nxt = flush_r;
    k_nxt     = k_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) state_nxt = ST_RD1;
      end
      ST_RD1: state_nxt = ST_RD2;
      ST_RD2: state_nxt = ST_CALC;
      ST_CALC: begin
        if (fire) begin
          if (!done) begin
            flush_nxt = 1'b1;
            k_nxt     = flush_r ? k_r + CW'(1) : '0;
            state_nxt = ST_RD1;
          end else begin
            flush_nxt = 1'b0;
            state_nxt = q_valid ? ST_RD1 : ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (load) k_nxt = head_col;
  end

  // line store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (fire && !flush_r) begin
      store[waddr] <= cell_r;
    end
    if (state_r == ST_RD1 || state_r == ST_RD2) begin
      rd0_r <= store[raddr0];
      rd1_r <= store[raddr1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      flush_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      flush_r <= flush_nxt;
      if (fire && need_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    k_r <= k_nxt;
    if (load) begin
      cell_r  <= head_cell;
      row_r   <= head_row;
      flags_r <= head_flags;
    end
    if (state_r == ST_RD2) begin
      left_r   <= rd0_r;
      centre_r <= rd1_r;
    end
    if (fire && need_out) begin
      out_state_r <= res;
      out_row_r   <= flush_r ? tsga_pkg::ROW_INDEX_W'(row_r)
                             : tsga_pkg::ROW_INDEX_W'(row_r - RW'(1));
      out_col_r   <= tsga_pkg::COL_INDEX_W'(k_r);
      out_end_r   <= flush_r && (k_r == w_last);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_next_state   = out_state_r;
  assign out_row_index    = out_row_r;
  assign out_column_index = out_col_r;
  assign out_frame_end    = out_end_r;

endmodule

// ===== hdl/tsga_checker.sv =====
// port-level checks on the grid automaton step, bound to the top level
module tsga_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [tsga_pkg::STATE_W-1:0]     out_next_state,
  input logic [tsga_pkg::ROW_INDEX_W-1:0] out_row_index,
  input logic [tsga_pkg::COL_INDEX_W-1:0] out_column_index,
  input logic                             out_frame_end
);

  // no result beat in the cycle after reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  // the rule never yields the spare code
  a_state_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_next_state != tsga_pkg::CELL_ALT)
    else $error("result carries code three");

  // a stalled result beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_next_state) &&
      $stable(out_row_index) && $stable(out_column_index) && $stable(out_frame_end))
    else $error("stalled result beat changed");

  // after the frame's last beat the next frame starts at column zero
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_frame_end |=> !out_valid || out_column_index == '0)
    else $error("frame did not restart at column zero");

endmodule

bind three_state_grid_automaton_step tsga_checker u_tsga_checker (.*);

// ===== dv/testbench.sv =====
// self-checking testbench for the three-state grid automaton step, with a next-generation tracker
module testbench;

  // one result beat: next generation of one cell and where it sits
  typedef struct packed {
    logic [tsga_pkg::STATE_W-1:0]     state;
    logic [tsga_pkg::ROW_INDEX_W-1:0] row;
    logic [tsga_pkg::COL_INDEX_W-1:0] col;
    logic                             last;
  } gen_cell_t;

  // unused register index, a write there must leave the frame position alone
  localparam logic [tsga_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  // room for the back end to finish cells that give no result (queue plus one in flight)
  localparam int SETTLE_CYCLES = 48;
  // receiver hold-off long enough to back the queue up and stall the input side
  localparam int LONG_HOLD     = 300;
  // hard stop, far beyond the slowest correct run
  localparam int LIMIT_TIME    = 8000000;

  // tracks the grid as the block sees it and predicts each next-generation beat
  class generation_tracker;
    logic [tsga_pkg::STATE_W-1:0]       lines [2][tsga_pkg::DEF_MAX_WIDTH];
    int unsigned                        col_pos;
    int unsigned                        row_pos;
    logic [tsga_pkg::GRID_WIDTH_W-1:0]  width_reg;
    logic [tsga_pkg::GRID_HEIGHT_W-1:0] height_reg;
    gen_cell_t                          due_cells [$];
    int                                 faults;

    function new();
      foreach (lines[s, c]) lines[s][c] = tsga_pkg::CELL_OFF;
      col_pos    = 0;
      row_pos    = 0;
      width_reg  = tsga_pkg::GRID_WIDTH_RESET;
      height_reg = tsga_pkg::GRID_HEIGHT_RESET;
      faults     = 0;
    endfunction

    function int unsigned used_width();
      int unsigned w;
      w = width_reg;
      if (w < 1) w = 1;
      if (w > tsga_pkg::DEF_MAX_WIDTH) w = tsga_pkg::DEF_MAX_WIDTH;
      return w;
    endfunction

    function int unsigned used_height();
      int unsigned h;
      h = height_reg;
      if (h < 1) h = 1;
      if (h > tsga_pkg::DEF_MAX_HEIGHT) h = tsga_pkg::DEF_MAX_HEIGHT;
      return h;
    endfunction

    function logic [tsga_pkg::STATE_W-1:0] evolve(logic [tsga_pkg::STATE_W-1:0] centre,
                                                  bit any_on);
      case (centre)
        tsga_pkg::CELL_ON: begin
          return tsga_pkg::CELL_DEAD;
        end
        tsga_pkg::CELL_DEAD: begin
          return tsga_pkg::CELL_OFF;
        end
        default: begin
          return any_on ? tsga_pkg::CELL_ON : tsga_pkg::CELL_OFF;
        end
      endcase
    endfunction

    function void configure(logic [tsga_pkg::CFG_INDEX_W-1:0] idx,
                            logic [tsga_pkg::CFG_DATA_W-1:0] val);
      if (idx == tsga_pkg::REG_GRID_WIDTH) begin
        width_reg = val[tsga_pkg::GRID_WIDTH_W-1:0];
      end else if (idx == tsga_pkg::REG_GRID_HEIGHT) begin
        height_reg = val;
      end else begin
        return;
      end
      col_pos = 0;
      row_pos = 0;
    endfunction

    function void expect_cell(logic [tsga_pkg::STATE_W-1:0] st, int unsigned r,
                              int unsigned c, bit last);
      gen_cell_t item;
      item.state = st;
      item.row   = r[tsga_pkg::ROW_INDEX_W-1:0];
      item.col   = c[tsga_pkg::COL_INDEX_W-1:0];
      item.last  = last;
      due_cells.push_back(item);
    endfunction

    // one accepted cell: results for the row above, and the final row on the frame's last cell
    function void take_cell(logic [tsga_pkg::STATE_W-1:0] raw);
      int unsigned                  w;
      int unsigned                  h;
      int unsigned                  c;
      int unsigned                  r;
      int unsigned                  here;
      int unsigned                  above;
      logic [tsga_pkg::STATE_W-1:0] incoming;
      bit                           any_on;
      w        = used_width();
      h        = used_height();
      c        = col_pos;
      r        = row_pos;
      incoming = (raw == tsga_pkg::CELL_ALT) ? tsga_pkg::CELL_OFF : raw;
      if (c >= w || r >= h) begin
        c = 0;
        r = 0;
      end
      here  = r & 1;
      above = here ^ 1;
      if (r >= 1) begin
        any_on = (incoming == tsga_pkg::CELL_ON);
        if (r >= 2 && lines[here][c] == tsga_pkg::CELL_ON) any_on = 1'b1;
        if (c > 0 && lines[above][c-1] == tsga_pkg::CELL_ON) any_on = 1'b1;
        if (c + 1 < w && lines[above][c+1] == tsga_pkg::CELL_ON) any_on = 1'b1;
        expect_cell(evolve(lines[above][c], any_on), r - 1, c, 1'b0);
      end
      lines[here][c] = incoming;
      if (r == h - 1 && c == w - 1) begin
        for (int k = 0; k < w; k++) begin
          any_on = 1'b0;
          if (r >= 1 && lines[above][k] == tsga_pkg::CELL_ON) any_on = 1'b1;
          if (k > 0 && lines[here][k-1] == tsga_pkg::CELL_ON) any_on = 1'b1;
          if (k + 1 < w && lines[here][k+1] == tsga_pkg::CELL_ON) any_on = 1'b1;
          expect_cell(evolve(lines[here][k], any_on), r, k, k == w - 1);
        end
        col_pos = 0;
        row_pos = 0;
      end else begin
        c++;
        if (c >= w) begin
          c = 0;
          r++;
        end
        col_pos = c;
        row_pos = r;
      end
    endfunction

    function int pending();
      return due_cells.size();
    endfunction

    task note_fault(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      faults++;
    endtask

    task match_result(gen_cell_t got);
      gen_cell_t want;
      if (due_cells.size() == 0) begin
        note_fault($sformatf("result row %0d col %0d with nothing due", got.row, got.col));
        return;
      end
      want = due_cells.pop_front();
      if (got.state !== want.state)
        note_fault($sformatf("row %0d col %0d next_state %0d, want %0d",
                             want.row, want.col, got.state, want.state));
      if (got.row !== want.row)
        note_fault($sformatf("row_index %0d, want %0d", got.row, want.row));
      if (got.col !== want.col)
        note_fault($sformatf("column_index %0d, want %0d", got.col, want.col));
      if (got.last !== want.last)
        note_fault($sformatf("row %0d col %0d frame_end %0b, want %0b",
                             want.row, want.col, got.last, want.last));
    endtask

    task close_out();
      if (due_cells.size() != 0)
        note_fault($sformatf("%0d results never arrived", due_cells.size()));
    endtask
  endclass

  logic                               clk = 1'b0;
  logic                               rst_n;
  logic                               in_valid;
  logic                               in_stall;
  logic [tsga_pkg::STATE_W-1:0]       in_cell_state;
  logic                               out_valid;
  logic                               out_stall;
  logic [tsga_pkg::STATE_W-1:0]       out_next_state;
  logic [tsga_pkg::ROW_INDEX_W-1:0]   out_row_index;
  logic [tsga_pkg::COL_INDEX_W-1:0]   out_column_index;
  logic                               out_frame_end;
  logic                               cfg_valid;
  logic                               cfg_ready;
  logic [tsga_pkg::CFG_INDEX_W-1:0]   cfg_index;
  logic [tsga_pkg::CFG_DATA_W-1:0]    cfg_data;

  generation_tracker tracker;
  // set by the stimulus side, picked up by the receiver at the next falling edge
  bit hold_request;

  // random grid phases: width and height as written (out-of-range ones included) and cell count
  int phase_w [8] = '{32, 5, 63, 2, 0, 7, 4, 1};
  int phase_h [8] = '{1024, 4, 2047, 1, 6, 3, 0, 2};
  int phase_n [8] = '{80, 60, 70, 30, 24, 63, 20, 24};
  localparam int PAUSE_PHASE = 1;
  localparam int HOLD_PHASE  = 5;

  three_state_grid_automaton_step dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cell_state    (in_cell_state),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_next_state   (out_next_state),
    .out_row_index    (out_row_index),
    .out_column_index (out_column_index),
    .out_frame_end    (out_frame_end),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // everything is sampled on the rising edge, before the block's own updates land;
  // register writes, accepted cells and result beats are handled in that order
  always @(posedge clk) begin : watch
    gen_cell_t seen;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) tracker.configure(cfg_index, cfg_data);
      if (in_valid && !in_stall) tracker.take_cell(in_cell_state);
      if (out_valid && !out_stall) begin
        seen.state = out_next_state;
        seen.row   = out_row_index;
        seen.col   = out_column_index;
        seen.last  = out_frame_end;
        tracker.match_result(seen);
      end
    end
  end

  // receiver: stall pattern cycles through free-running, sparse random, periodic and
  // heavy random stretches; a requested hold-off keeps it stalled until LONG_HOLD runs out
  initial begin
    int cyc;
    int hold_left;
    cyc       = 0;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case ((cyc / 40) % 4)
          0: begin
            out_stall <= 1'b0;
          end
          1: begin
            out_stall <= ($urandom_range(0, 2) == 0);
          end
          2: begin
            out_stall <= (cyc % 5 < 2);
          end
          default: begin
            out_stall <= 1'($urandom_range(0, 1));
          end
        endcase
      end
    end
  end

  // watchdog
  initial begin
    #LIMIT_TIME;
    $display("** three_state_grid_automaton_step: FAILED **");
    $finish;
  end

  // live and off cells alike and a fair share of dead ones so that all three rules fire often;
  // the alternative off code turns up now and then
  function automatic logic [tsga_pkg::STATE_W-1:0] random_cell();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 3) return tsga_pkg::CELL_OFF;
    if (pick < 6) return tsga_pkg::CELL_ON;
    if (pick < 8) return tsga_pkg::CELL_DEAD;
    return tsga_pkg::CELL_ALT;
  endfunction

  // offer one cell beat and hold it until it is taken
  task send_cell(input logic [tsga_pkg::STATE_W-1:0] v);
    @(negedge clk);
    in_valid      <= 1'b1;
    in_cell_state <= v;
    do @(posedge clk); while (in_stall);
  endtask

  // drop valid, payload wanders meanwhile
  task go_quiet(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid      <= 1'b0;
      in_cell_state <= tsga_pkg::STATE_W'($urandom_range(0, 3));
    end
  endtask

  task wait_drained();
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // every result in, then time for row-0 cells still in the back end
  task settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task write_reg(input logic [tsga_pkg::CFG_INDEX_W-1:0] idx,
                 input logic [tsga_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task set_grid(input int w, input int h);
    settle();
    write_reg(tsga_pkg::REG_GRID_WIDTH, tsga_pkg::CFG_DATA_W'(w));
    write_reg(tsga_pkg::REG_GRID_HEIGHT, tsga_pkg::CFG_DATA_W'(h));
  endtask

  // directed cells with random gaps in between
  task play(input logic [tsga_pkg::STATE_W-1:0] cells [$]);
    foreach (cells[i]) begin
      if ($urandom_range(0, 2) == 0) go_quiet($urandom_range(1, 3));
      send_cell(cells[i]);
    end
    go_quiet(1);
  endtask

  // random cells in bursts; optionally a mid-phase drain with a write to the unused
  // index (frame must carry on), and optionally a long receiver hold-off
  task run_cells(input int count, input bit hold_mid, input bit pause_mid);
    int burst;
    int gap;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (pause_mid && i == count / 2) begin
        go_quiet(1);
        settle();
        write_reg(REG_UNUSED, tsga_pkg::CFG_DATA_W'($urandom_range(0, 2047)));
      end
      if (hold_mid && i == count / 4) hold_request = 1'b1;
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        gap   = $urandom_range(0, 5);
        if (gap > 0) go_quiet(gap);
      end
      send_cell(random_cell());
      burst--;
    end
    go_quiet(1);
  endtask

  initial begin
    logic [tsga_pkg::STATE_W-1:0] cells [$];
    tracker       = new();
    hold_request  = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_cell_state = tsga_pkg::CELL_OFF;
    cfg_valid     = 1'b0;
    cfg_index     = tsga_pkg::REG_GRID_WIDTH;
    cfg_data      = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // 3x3 frame: every rule, the alternative off code, corner and edge neighbours
    set_grid(3, 3);
    cells = {tsga_pkg::CELL_ON,  tsga_pkg::CELL_OFF,  tsga_pkg::CELL_ALT,
             tsga_pkg::CELL_OFF, tsga_pkg::CELL_DEAD, tsga_pkg::CELL_OFF,
             tsga_pkg::CELL_ALT, tsga_pkg::CELL_ON,   tsga_pkg::CELL_DEAD};
    play(cells);

    // zero width and height act as one: every beat is a whole frame and flushes at once
    set_grid(0, 0);
    cells = {tsga_pkg::CELL_ON, tsga_pkg::CELL_DEAD, tsga_pkg::CELL_OFF, tsga_pkg::CELL_ALT};
    play(cells);

    // single column: only vertical neighbours count
    set_grid(1, 4);
    cells = {tsga_pkg::CELL_OFF, tsga_pkg::CELL_ON, tsga_pkg::CELL_OFF, tsga_pkg::CELL_ALT};
    play(cells);

    // random phases, from full-size defaults through clamped and degenerate grids
    for (int p = 0; p < 8; p++) begin
      set_grid(phase_w[p], phase_h[p]);
      run_cells(phase_n[p], p == HOLD_PHASE, p == PAUSE_PHASE);
    end

    wait_drained();
    repeat (100) @(posedge clk);
    tracker.close_out();
    if (tracker.faults == 0) begin
      $display("** three_state_grid_automaton_step: PASSED **");
    end else begin
      $display("** three_state_grid_automaton_step: FAILED **");
    end
    $finish;
  end

endmodule
